// File: design/cmaob_pkg.sv
// ----------------------------------------------------------------------------
// cmaob_pkg
// Shared types and constants for the coverage-masked over blend pipeline.
// ----------------------------------------------------------------------------
package cmaob_pkg;

    localparam logic [15:0] FULL_SQ    = 16'd65025;   // 255 * 255
    localparam logic [24:0] ALPHA_DIV  = 25'd130050;  // 2 * 65025
    localparam logic [24:0] ALPHA_BIAS = 25'd65025;

    localparam int unsigned FRONT_STAGES = 4;
    localparam int unsigned DIV_STAGES   = 8;         // one quotient bit each
    localparam int unsigned NUM_STG      = FRONT_STAGES + DIV_STAGES;

    // Configuration register indexes
    localparam logic [1:0] REG_SOURCE_RED     = 2'd0;
    localparam logic [1:0] REG_SOURCE_GREEN   = 2'd1;
    localparam logic [1:0] REG_SOURCE_BLUE    = 2'd2;
    localparam logic [1:0] REG_SOURCE_OPACITY = 2'd3;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       frame_end;
    } cmaob_pix_t;

    // Divider state that travels down the quotient stages
    typedef struct packed {
        logic [32:0] rem_b;
        logic [32:0] rem_g;
        logic [32:0] rem_r;
        logic [24:0] rem_a;
        logic [24:0] dvs;
        logic [7:0]  q_b;
        logic [7:0]  q_g;
        logic [7:0]  q_r;
        logic [7:0]  q_a;
        logic        bypass;
        cmaob_pix_t  pix;
    } cmaob_div_t;

endpackage

// File: design/cmaob_front.sv
// ----------------------------------------------------------------------------
// cmaob_front
// Four register stages: source alpha, blend weights, channel products, and
// the rounded dividends and divisor for the quotient stages.
// ----------------------------------------------------------------------------
module cmaob_front
    import cmaob_pkg::*;
(
    input  logic                     aclk,
    input  logic [FRONT_STAGES-1:0]  en,
    input  logic [7:0]               src_red,
    input  logic [7:0]               src_green,
    input  logic [7:0]               src_blue,
    input  logic [7:0]               src_opacity,
    input  logic [7:0]               coverage,
    input  cmaob_pix_t               pix,
    output cmaob_div_t               div_out
);

    // stage 1
    logic [15:0] a1_reg, a1_next;
    logic        byp1_reg;
    cmaob_pix_t  pix1_reg;
    // stage 2
    logic [23:0] w1_reg, w1_next;
    logic [23:0] w2_reg, w2_next;
    logic        byp2_reg;
    cmaob_pix_t  pix2_reg;
    // stage 3
    logic [31:0] pb_reg, pg_reg, pr_reg;
    logic [31:0] qb_reg, qg_reg, qr_reg;
    logic [31:0] pb_next, pg_next, pr_next;
    logic [31:0] qb_next, qg_next, qr_next;
    logic [23:0] n3_reg, n3_next;
    logic        byp3_reg;
    cmaob_pix_t  pix3_reg;
    // stage 4
    cmaob_div_t  div_reg, div_next;
    logic [31:0] sum_b, sum_g, sum_r;

    always_comb begin
        a1_next = {8'b0, coverage} * {8'b0, src_opacity};

        // weight of source is A*255, weight of destination is Da*(65025-A)
        w1_next = {a1_reg, 8'b0} - {8'b0, a1_reg};
        w2_next = {16'b0, pix1_reg.alpha} * {8'b0, FULL_SQ - a1_reg};

        pb_next = {24'b0, src_blue}       * {8'b0, w1_reg};
        pg_next = {24'b0, src_green}      * {8'b0, w1_reg};
        pr_next = {24'b0, src_red}        * {8'b0, w1_reg};
        qb_next = {24'b0, pix2_reg.blue}  * {8'b0, w2_reg};
        qg_next = {24'b0, pix2_reg.green} * {8'b0, w2_reg};
        qr_next = {24'b0, pix2_reg.red}   * {8'b0, w2_reg};
        n3_next = w1_reg + w2_reg;

        // round half up: (2*num + N) / (2*N)
        sum_b = pb_reg + qb_reg;
        sum_g = pg_reg + qg_reg;
        sum_r = pr_reg + qr_reg;
        div_next.rem_b  = {sum_b, 1'b0} + {9'b0, n3_reg};
        div_next.rem_g  = {sum_g, 1'b0} + {9'b0, n3_reg};
        div_next.rem_r  = {sum_r, 1'b0} + {9'b0, n3_reg};
        div_next.rem_a  = {n3_reg, 1'b0} + ALPHA_BIAS;
        div_next.dvs    = {n3_reg, 1'b0};
        div_next.q_b    = '0;
        div_next.q_g    = '0;
        div_next.q_r    = '0;
        div_next.q_a    = '0;
        div_next.bypass = byp3_reg;
        div_next.pix    = pix3_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a1_reg   <= a1_next;
            byp1_reg <= (coverage == 8'd0) || (src_opacity == 8'd0);
            pix1_reg <= pix;
        end
        if (en[1]) begin
            w1_reg   <= w1_next;
            w2_reg   <= w2_next;
            byp2_reg <= byp1_reg;
            pix2_reg <= pix1_reg;
        end
        if (en[2]) begin
            pb_reg   <= pb_next;
            pg_reg   <= pg_next;
            pr_reg   <= pr_next;
            qb_reg   <= qb_next;
            qg_reg   <= qg_next;
            qr_reg   <= qr_next;
            n3_reg   <= n3_next;
            byp3_reg <= byp2_reg;
            pix3_reg <= pix2_reg;
        end
        if (en[3]) begin
            div_reg <= div_next;
        end
    end

    assign div_out = div_reg;

endmodule

// File: design/cmaob_div_stage.sv
// ----------------------------------------------------------------------------
// cmaob_div_stage
// One restoring division step: resolves one quotient bit for the three color
// channels and the alpha, then registers the remainders.
// ----------------------------------------------------------------------------
module cmaob_div_stage
    import cmaob_pkg::*;
#(
    parameter int unsigned SHIFT = 0
) (
    input  logic       aclk,
    input  logic       en,
    input  cmaob_div_t d_in,
    output cmaob_div_t d_out
);

    localparam logic [2:0]  QBIT    = 3'(SHIFT);
    localparam logic [24:0] ADIV_SH = ALPHA_DIV << SHIFT;

    logic [32:0] dvs_sh;
    cmaob_div_t  d_reg, d_next;

    always_comb begin
        dvs_sh = {8'b0, d_in.dvs} << SHIFT;
        d_next = d_in;
        if (d_in.rem_b >= dvs_sh) begin
            d_next.rem_b       = d_in.rem_b - dvs_sh;
            d_next.q_b[QBIT]   = 1'b1;
        end
        if (d_in.rem_g >= dvs_sh) begin
            d_next.rem_g       = d_in.rem_g - dvs_sh;
            d_next.q_g[QBIT]   = 1'b1;
        end
        if (d_in.rem_r >= dvs_sh) begin
            d_next.rem_r       = d_in.rem_r - dvs_sh;
            d_next.q_r[QBIT]   = 1'b1;
        end
        if (d_in.rem_a >= ADIV_SH) begin
            d_next.rem_a       = d_in.rem_a - ADIV_SH;
            d_next.q_a[QBIT]   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// File: design/coverage_mask_alpha_over_blend.sv
// ----------------------------------------------------------------------------
// coverage_mask_alpha_over_blend
// Over blend of a solid configured color, scaled by coverage and opacity,
// onto one straight-alpha BGRA destination pixel per request.
// ----------------------------------------------------------------------------
// One pixel enters per clock while the output side is not stalled: four
// stages form the source alpha, the blend weights, the channel products and
// the rounded dividends, eight stages of a restoring divider resolve one
// quotient bit each for the three channels and the alpha, and one output
// register holds the result. A stall only stops the stages that are
// occupied, so bubbles close up and requests are taken while a result
// waits until the pipeline is full. Write the color and opacity registers
// only while the pipeline is empty; they are read by the stages directly.
module coverage_mask_alpha_over_blend
    import cmaob_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wr_data,
    // input pixels
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_coverage,
    input  logic [7:0] s_dest_blue,
    input  logic [7:0] s_dest_green,
    input  logic [7:0] s_dest_red,
    input  logic [7:0] s_dest_alpha,
    input  logic       s_frame_end,
    // blended pixels
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_blue,
    output logic [7:0] m_out_green,
    output logic [7:0] m_out_red,
    output logic [7:0] m_out_alpha,
    output logic       m_frame_end_out
);

    logic [7:0] red_reg, green_reg, blue_reg, opacity_reg;

    logic [NUM_STG-1:0] vld_reg;
    logic [NUM_STG:0]   en;
    logic               m_valid_reg;

    cmaob_pix_t in_pix;
    cmaob_div_t div_chain [DIV_STAGES+1];
    cmaob_div_t res;

    logic [7:0] ob_reg, og_reg, or_reg, oa_reg;
    logic       ofe_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg     <= 8'd255;
            green_reg   <= 8'd255;
            blue_reg    <= 8'd255;
            opacity_reg <= 8'd255;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SOURCE_RED:     red_reg     <= cfg_wr_data;
                REG_SOURCE_GREEN:   green_reg   <= cfg_wr_data;
                REG_SOURCE_BLUE:    blue_reg    <= cfg_wr_data;
                REG_SOURCE_OPACITY: opacity_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances
    always_comb begin
        en[NUM_STG] = !m_valid_reg || m_ready;
        for (int k = NUM_STG - 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
            if (en[NUM_STG]) begin
                m_valid_reg <= vld_reg[NUM_STG-1];
            end
        end
    end

    assign in_pix.blue      = s_dest_blue;
    assign in_pix.green     = s_dest_green;
    assign in_pix.red       = s_dest_red;
    assign in_pix.alpha     = s_dest_alpha;
    assign in_pix.frame_end = s_frame_end;

    cmaob_front u_front (
        .aclk        (aclk),
        .en          (en[FRONT_STAGES-1:0]),
        .src_red     (red_reg),
        .src_green   (green_reg),
        .src_blue    (blue_reg),
        .src_opacity (opacity_reg),
        .coverage    (s_coverage),
        .pix         (in_pix),
        .div_out     (div_chain[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        cmaob_div_stage #(
            .SHIFT (DIV_STAGES - 1 - g)
        ) u_div (
            .aclk  (aclk),
            .en    (en[FRONT_STAGES+g]),
            .d_in  (div_chain[g]),
            .d_out (div_chain[g+1])
        );
    end

    assign res = div_chain[DIV_STAGES];

    // Zero source alpha passes the destination pixel unchanged
    always_ff @(posedge aclk) begin
        if (en[NUM_STG]) begin
            ob_reg  <= res.bypass ? res.pix.blue  : res.q_b;
            og_reg  <= res.bypass ? res.pix.green : res.q_g;
            or_reg  <= res.bypass ? res.pix.red   : res.q_r;
            oa_reg  <= res.bypass ? res.pix.alpha : res.q_a;
            ofe_reg <= res.pix.frame_end;
        end
    end

    assign s_ready         = en[0];
    assign m_valid         = m_valid_reg;
    assign m_out_blue      = ob_reg;
    assign m_out_green     = og_reg;
    assign m_out_red       = or_reg;
    assign m_out_alpha     = oa_reg;
    assign m_frame_end_out = ofe_reg;

endmodule

// File: design/cmaob_checker.sv
// ----------------------------------------------------------------------------
// cmaob_checker
// Port-level checks on the blend pipeline: result hold, ready behavior and
// request accounting.
// ----------------------------------------------------------------------------
module cmaob_checker
    import cmaob_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_blue,
    input logic [7:0] m_out_green,
    input logic [7:0] m_out_red,
    input logic [7:0] m_out_alpha,
    input logic       m_frame_end_out
);

    logic [4:0] inflight_reg;
    logic       s_acc, m_acc;

    assign s_acc = s_valid && s_ready;
    assign m_acc = m_valid && m_ready;

    // Requests taken but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else if (s_acc && !m_acc) begin
            inflight_reg <= inflight_reg + 5'd1;
        end else if (m_acc && !s_acc) begin
            inflight_reg <= inflight_reg - 5'd1;
        end
    end

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_blue) && $stable(m_out_green)
            && $stable(m_out_red) && $stable(m_out_alpha) && $stable(m_frame_end_out))
        else $error("result changed while stalled");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while output side is free");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        (inflight_reg == 5'd0) |-> !m_valid)
        else $error("result without a pending request");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 5'(NUM_STG + 1))
        else $error("more requests in flight than pipeline stages");

endmodule

bind coverage_mask_alpha_over_blend cmaob_checker u_cmaob_checker (.*);
